// ===== rtl/npm_pkg.sv =====
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants for the nearest point match block.
// ----------------------------------------------------------------------------
package npm_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W        = 32;
  localparam int QIDX_W         = 16;
  localparam int MIDX_W         = 10;
  localparam int SQ_W           = 2 * COORD_W;

  // Hard cap of 20 units in Q16.16, squared for comparison with squared distances.
  localparam logic [SQ_W-1:0] CAP_Q16 = SQ_W'(20) << 16;
  localparam logic [SQ_W-1:0] CAP_SQ  = CAP_Q16 * CAP_Q16;

  localparam logic [COORD_W-1:0] THR_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic out_load;
  } ctrl_t;

endpackage

// ===== rtl/npm_if.sv =====
// ----------------------------------------------------------------------------
// npm_if
// Valid/ready channels for input items and query results.
// ----------------------------------------------------------------------------
interface npm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             op;
  logic signed [npm_pkg::COORD_W-1:0]     point_x;
  logic signed [npm_pkg::COORD_W-1:0]     point_y;
  logic signed [npm_pkg::COORD_W-1:0]     point_z;

  modport source (output valid, output op, output point_x, output point_y,
                  output point_z, input ready);
  modport sink   (input valid, input op, input point_x, input point_y,
                  input point_z, output ready);
endinterface

interface npm_out_if;
  logic                          valid;
  logic                          ready;
  logic [npm_pkg::QIDX_W-1:0]    query_index;
  logic                          matched;
  logic [npm_pkg::MIDX_W-1:0]    match_index;

  modport source (output valid, output query_index, output matched,
                  output match_index, input ready);
  modport sink   (input valid, input query_index, input matched,
                  input match_index, output ready);
endinterface

// ===== rtl/npm_store.sv =====
// ----------------------------------------------------------------------------
// npm_store
// Reference point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module npm_store #(
  parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(MAX_POINTS)-1:0]     waddr,
  input  logic [3*npm_pkg::COORD_W-1:0]     wdata,
  input  logic                              re,
  input  logic [$clog2(MAX_POINTS)-1:0]     raddr,
  output logic [3*npm_pkg::COORD_W-1:0]     rdata
);

  logic [3*npm_pkg::COORD_W-1:0] mem [MAX_POINTS];
  logic [3*npm_pkg::COORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/npm_dist.sv =====
// ----------------------------------------------------------------------------
// npm_dist
// Three-stage squared distance pipeline: absolute difference, square, and
// saturating sum of the three axes.
// ----------------------------------------------------------------------------
module npm_dist #(
  parameter int IDX_W = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [IDX_W-1:0]                  in_idx,
  input  logic [3*npm_pkg::COORD_W-1:0]     ref_pt,
  input  logic [3*npm_pkg::COORD_W-1:0]     qry_pt,
  output logic                              busy,
  output logic                              out_vld,
  output logic [IDX_W-1:0]                  out_idx,
  output logic [npm_pkg::SQ_W-1:0]          out_dist
);

  localparam int CW = npm_pkg::COORD_W;
  localparam int SW = npm_pkg::SQ_W;

  logic [2:0]          vld_r;
  logic [IDX_W-1:0]    idx_a_r, idx_b_r, idx_c_r;
  logic [CW-1:0]       abs_r   [3];
  logic [CW-1:0]       abs_nxt [3];
  logic [SW-1:0]       sq_r    [3];
  logic [SW+1:0]       sum;
  logic [SW-1:0]       dist_r;
  logic [SW-1:0]       dist_nxt;

  always_comb begin
    logic signed [CW:0] d;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d = $signed({qry_pt[k*CW+CW-1], qry_pt[k*CW +: CW]})
        - $signed({ref_pt[k*CW+CW-1], ref_pt[k*CW +: CW]});
      abs_nxt[k] = d[CW] ? CW'(-d) : d[CW-1:0];
    end
  end

  assign sum      = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  assign dist_nxt = (sum[SW+1:SW] != 2'b00) ? '1 : sum[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    idx_a_r <= in_idx;
    idx_b_r <= idx_a_r;
    idx_c_r <= idx_b_r;
    for (int k = 0; k < 3; k++) begin
      abs_r[k] <= abs_nxt[k];
      sq_r[k]  <= SW'(abs_r[k]) * SW'(abs_r[k]);
    end
    dist_r <= dist_nxt;
  end

  assign busy     = |vld_r;
  assign out_vld  = vld_r[2];
  assign out_idx  = idx_c_r;
  assign out_dist = dist_r;

endmodule

// ===== rtl/nearest_point_match_top.sv =====
// ----------------------------------------------------------------------------
// nearest_point_match_top
// Brute-force nearest point search over a memory of reference points.
// ----------------------------------------------------------------------------
// Clear and append beats return no result.
// A query reads each stored point from memory once (an empty store skips the reads),
// then waits for the distance pipeline to drain before its result is formed.
// One item is in work at a time; the next beat is taken once the result is registered.
// Reset clears the point count, query counter and threshold (to 1.0); the point
// memory itself is not cleared and needs no sweep.
module nearest_point_match_top #(
  parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  npm_in_if.sink                         in_bus,
  npm_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [npm_pkg::COORD_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = npm_pkg::COORD_W;
  localparam int SW    = npm_pkg::SQ_W;

  npm_pkg::state_t state_r, state_nxt;
  npm_pkg::ctrl_t  ctrl;

  logic [CW-1:0]               thr_r;
  logic [SW-1:0]               thr_sq_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            scan_r;
  logic [npm_pkg::QIDX_W-1:0]  qcnt_r;
  logic [npm_pkg::QIDX_W-1:0]  qidx_r;
  logic [3*CW-1:0]             qry_r;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic                        best_vld_r;
  logic [SW-1:0]               best_r;
  logic [IDX_W-1:0]            best_idx_r;

  logic                        out_valid_r;
  logic                        out_matched_r;
  logic [npm_pkg::MIDX_W-1:0]  out_midx_r;
  logic [npm_pkg::QIDX_W-1:0]  out_qidx_r;

  logic                        accept;
  logic                        is_append;
  logic                        is_query;
  logic                        last_read;
  logic [3*CW-1:0]             ref_pt;
  logic                        dist_busy;
  logic                        dist_vld;
  logic [IDX_W-1:0]            dist_idx;
  logic [SW-1:0]               cur_dist;
  logic                        hit;
  logic [IDX_W+npm_pkg::MIDX_W-1:0] best_idx_ext;

  assign accept    = in_bus.valid && ctrl.in_ready;
  assign is_append = accept && (in_bus.op == npm_pkg::OP_APPEND);
  assign is_query  = accept && (in_bus.op == npm_pkg::OP_QUERY);
  assign last_read = (CNT_W'(scan_r + 1'b1) == count_r);

  npm_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (is_append && (count_r < CNT_W'(MAX_POINTS))),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({in_bus.point_z, in_bus.point_y, in_bus.point_x}),
    .re    (ctrl.rd_en),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (ref_pt)
  );

  npm_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .in_idx   (rd_idx_r),
    .ref_pt   (ref_pt),
    .qry_pt   (qry_r),
    .busy     (dist_busy),
    .out_vld  (dist_vld),
    .out_idx  (dist_idx),
    .out_dist (cur_dist)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npm_pkg::ST_IDLE: begin
        if (is_query) begin
          state_nxt = (count_r == '0) ? npm_pkg::ST_DRAIN : npm_pkg::ST_SCAN;
        end
      end
      npm_pkg::ST_SCAN: begin
        if (last_read) begin
          state_nxt = npm_pkg::ST_DRAIN;
        end
      end
      npm_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !dist_busy) begin
          state_nxt = npm_pkg::ST_DONE;
        end
      end
      npm_pkg::ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          state_nxt = npm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npm_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    ctrl = '0;
    case (state_r)
      npm_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      npm_pkg::ST_SCAN: ctrl.rd_en    = 1'b1;
      npm_pkg::ST_DONE: ctrl.out_load = !out_valid_r || out_bus.ready;
      default:          ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npm_pkg::ST_IDLE;
      thr_r       <= npm_pkg::THR_RESET;
      count_r     <= '0;
      qcnt_r      <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ctrl.rd_en;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (accept) begin
        case (in_bus.op)
          npm_pkg::OP_CLEAR: begin
            count_r <= '0;
            qcnt_r  <= '0;
          end
          npm_pkg::OP_APPEND: begin
            if (count_r < CNT_W'(MAX_POINTS)) begin
              count_r <= count_r + 1'b1;
            end
          end
          npm_pkg::OP_QUERY: begin
            qcnt_r     <= qcnt_r + 1'b1;
            scan_r     <= '0;
            best_vld_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (ctrl.rd_en) begin
        scan_r <= scan_r + 1'b1;
      end
      // Earliest point wins a tie: only a strictly smaller distance replaces it.
      if (dist_vld && (!best_vld_r || cur_dist < best_r)) begin
        best_vld_r <= 1'b1;
      end
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign hit          = best_vld_r && (best_r < npm_pkg::CAP_SQ) && (best_r < thr_sq_r);
  assign best_idx_ext = {{npm_pkg::MIDX_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    thr_sq_r <= SW'(thr_r) * SW'(thr_r);
    rd_idx_r <= scan_r[IDX_W-1:0];
    if (is_query) begin
      qry_r  <= {in_bus.point_z, in_bus.point_y, in_bus.point_x};
      qidx_r <= qcnt_r;
    end
    if (dist_vld && (!best_vld_r || cur_dist < best_r)) begin
      best_r     <= cur_dist;
      best_idx_r <= dist_idx;
    end
    if (ctrl.out_load) begin
      out_qidx_r    <= qidx_r;
      out_matched_r <= hit;
      out_midx_r    <= hit ? best_idx_ext[npm_pkg::MIDX_W-1:0] : '0;
    end
  end

  assign in_bus.ready        = ctrl.in_ready;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.query_index = out_qidx_r;
  assign out_bus.matched     = out_matched_r;
  assign out_bus.match_index = out_midx_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds capacity");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_en |-> scan_r < count_r)
    else $error("memory read beyond stored points");

  a_drained_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == npm_pkg::ST_DONE |-> !rd_vld_r && !dist_busy)
    else $error("result formed while distances still in flight");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.matched |-> out_bus.match_index == '0)
    else $error("match index set without a match");

endmodule
